>>> design/ifx_pkg.sv
// Shared constants, codes and helper functions for the infix expression evaluator.
// Used by ifx_if, ifx_mul and the top level; depends on nothing.
`default_nettype none

package ifx_pkg;

    localparam int STACK_DEPTH_DEF     = 32;
    localparam int VALUE_WIDTH_DEF     = 48;
    localparam int FRACTION_BITS_DEF   = 16;
    localparam int MAX_FRAC_DIGITS_DEF = 6;

    // multiplier chunk and width of the largest power of ten (1e9)
    localparam int MUL_CHUNK   = 16;
    localparam int POW10_WIDTH = 30;

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LROUND = 8'h28;
    localparam logic [7:0] CH_RROUND = 8'h29;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;
    localparam logic [7:0] CH_LSQR   = 8'h5B;
    localparam logic [7:0] CH_RSQR   = 8'h5D;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_ROUND  = 3'd4,
        OP_CURLY  = 3'd5,
        OP_SQUARE = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        BR_ROUND  = 2'd0,
        BR_CURLY  = 2'd1,
        BR_SQUARE = 2'd2
    } t_br;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BRACKET   = 2'd1,
        ST_DIV_ZERO  = 2'd2,
        ST_MALFORMED = 2'd3
    } t_status;

    // 10^n, capped at 10^9
    function automatic logic [POW10_WIDTH-1:0] pow10(input logic [3:0] n);
        logic [POW10_WIDTH-1:0] p;
        case (n)
            4'd0:    p = POW10_WIDTH'(1);
            4'd1:    p = POW10_WIDTH'(10);
            4'd2:    p = POW10_WIDTH'(100);
            4'd3:    p = POW10_WIDTH'(1000);
            4'd4:    p = POW10_WIDTH'(10000);
            4'd5:    p = POW10_WIDTH'(100000);
            4'd6:    p = POW10_WIDTH'(1000000);
            4'd7:    p = POW10_WIDTH'(10000000);
            4'd8:    p = POW10_WIDTH'(100000000);
            default: p = POW10_WIDTH'(1000000000);
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

>>> design/ifx_if.sv
// Valid/ready channel interfaces for characters in and results out.
// Depends on ifx_pkg for the default value width.
`default_nettype none

interface ifx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;
    modport source (output valid, character, last, input ready);
    modport sink   (input valid, character, last, output ready);
endinterface

interface ifx_out_if #(
    parameter int VALUE_WIDTH = ifx_pkg::VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic [1:0]             status;
    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

`default_nettype wire

>>> design/ifx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ifx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/ifx_mul.sv
// Multi-cycle unsigned multiplier, one MUL_CHUNK-bit digit of the multiplier per cycle.
// Depends on ifx_pkg.
`default_nettype none

module ifx_mul #(
    parameter int VALUE_WIDTH = ifx_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [VALUE_WIDTH-1:0]     i_a,
    input  wire logic [VALUE_WIDTH-1:0]     i_b,
    output      logic                       o_done,
    output      logic [2*VALUE_WIDTH-1:0]   o_prod
);

    localparam int CK   = ifx_pkg::MUL_CHUNK;
    localparam int NCH  = (VALUE_WIDTH + CK - 1) / CK;
    localparam int BW   = NCH * CK;
    localparam int CNTW = $clog2(NCH + 1);
    localparam int PW   = 2 * VALUE_WIDTH;

    logic [VALUE_WIDTH-1:0]    r_a;
    logic [BW-1:0]             r_b;
    logic [PW-1:0]             r_p;
    logic [CNTW-1:0]           r_cnt;
    logic                      r_run;
    logic                      r_done;
    logic [VALUE_WIDTH+CK-1:0] w_pp;

    assign w_pp = r_a * r_b[BW-1 -: CK];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNTW'(NCH);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= BW'(i_b);
            r_p <= '0;
        end else if (r_run) begin
            r_p <= (r_p << CK) + PW'(w_pp);
            r_b <= r_b << CK;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

`default_nettype wire

>>> design/ifx_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none

module ifx_div #(
    parameter int NUM_WIDTH = 64,
    parameter int DEN_WIDTH = 48
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [NUM_WIDTH-1:0] i_num,
    input  wire logic [DEN_WIDTH-1:0] i_den,
    output      logic                 o_done,
    output      logic [NUM_WIDTH-1:0] o_quot
);

    localparam int CNTW = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] r_n;
    logic [DEN_WIDTH-1:0] r_den;
    logic [DEN_WIDTH-1:0] r_rem;
    logic [CNTW-1:0]      r_cnt;
    logic                 r_run;
    logic                 r_done;
    logic [DEN_WIDTH:0]   w_trial;
    logic                 w_ge;
    logic [DEN_WIDTH:0]   w_diff;

    assign w_trial = {r_rem, r_n[NUM_WIDTH-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNTW'(NUM_WIDTH);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_run) begin
            r_n   <= {r_n[NUM_WIDTH-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_WIDTH-1:0] : w_trial[DEN_WIDTH-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_n;

endmodule

`default_nettype wire

>>> design/infix_expression_evaluator_unit.sv
// Top level of the infix expression evaluator: sequencer, stack RAMs, arithmetic units.
// Depends on ifx_pkg, ifx_if, ifx_ram, ifx_mul and ifx_div.
//
// Usage: characters of an expression arrive one request at a time on i_in
// (character, last). When the request flagged last has been processed, one
// result request leaves on o_out: a signed fixed-point value with
// FRACTION_BITS fraction bits and a 2-bit status (ok, bracket mismatch,
// divide by zero, malformed/overflow). Requests without last give no result.
// Timing: one character at a time. A digit, point or ignored character only
// passes through dispatch and the end check. The end of a number costs a
// conversion through the shared divider. Each operator reduction reads two
// numbers and one operator from the stack RAMs, which have registered reads,
// then runs the multiplier for a multiply or the bit-serial divider for a
// divide.
// Reset: synchronous, clears counts, error and number state; RAM contents
// are not cleared, the counts keep unwritten entries from being read.
// Stall: the result sits in an output register; a new expression may be
// accepted while it waits. A second result waits until the first is taken.
`default_nettype none

module infix_expression_evaluator_unit #(
    parameter int STACK_DEPTH         = ifx_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH         = ifx_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS       = ifx_pkg::FRACTION_BITS_DEF,
    parameter int MAX_FRACTION_DIGITS = ifx_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ifx_in_if.sink     i_in,
    ifx_out_if.source  o_out
);

    localparam int VW  = VALUE_WIDTH;
    localparam int FB  = FRACTION_BITS;
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int DW  = VW + FB;                       // divider numerator
    localparam int DVW = (VW > ifx_pkg::POW10_WIDTH) ? VW : ifx_pkg::POW10_WIDTH;
    localparam int MW  = (2 * VW > DW) ? 2 * VW : DW;   // magnitude before saturation

    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [16:0] {
        S_IDLE     = 17'b00000000000000001,
        S_DISPATCH = 17'b00000000000000010,
        S_FINISH   = 17'b00000000000000100,
        S_AFTER    = 17'b00000000000001000,
        S_BR_RD    = 17'b00000000000010000,
        S_RED_CHK  = 17'b00000000000100000,
        S_RED_OP   = 17'b00000000001000000,
        S_RD_Y     = 17'b00000000010000000,
        S_RD_X     = 17'b00000000100000000,
        S_ALU      = 17'b00000001000000000,
        S_MUL      = 17'b00000010000000000,
        S_DIV      = 17'b00000100000000000,
        S_RED_EXIT = 17'b00001000000000000,
        S_END_CHK  = 17'b00010000000000000,
        S_RES_RD   = 17'b00100000000000000,
        S_OUT      = 17'b01000000000000000,
        S_SPARE    = 17'b10000000000000000
    } t_state;

    typedef enum logic [1:0] {
        K_OP    = 2'd0,
        K_OPEN  = 2'd1,
        K_CLOSE = 2'd2,
        K_END   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_INT  = 2'd1,
        PH_FRAC = 2'd2
    } t_phase;

    // magnitude plus sign -> saturated two's complement
    function automatic logic [VW-1:0] sat_signed(input logic [MW-1:0] m, input logic neg);
        logic [MW-1:0] lim;
        logic [VW-1:0] lo;
        lim = MW'(VMAX) + MW'(neg);
        lo  = m[VW-1:0];
        if (m > lim) begin
            return neg ? VMIN : VMAX;
        end
        return neg ? (~lo + VW'(1)) : lo;
    endfunction

    t_state          r_state, n_state;
    t_kind           r_kind, n_kind;
    logic [7:0]      r_char;
    logic            r_last;
    ifx_pkg::t_op    r_newop, n_newop;
    ifx_pkg::t_op    r_op, n_op;
    ifx_pkg::t_br    r_br, n_br;
    logic [CW-1:0]   r_num_cnt, n_num_cnt;
    logic [CW-1:0]   r_op_cnt, n_op_cnt;
    logic [CW-1:0]   r_br_cnt, n_br_cnt;
    logic [VW-1:0]   r_acc, n_acc;
    logic [3:0]      r_frac, n_frac;
    t_phase          r_phase, n_phase;
    ifx_pkg::t_status r_err, n_err;
    logic [VW-1:0]   r_x, n_x;
    logic [VW-1:0]   r_y, n_y;
    logic            r_neg, n_neg;
    logic            r_div_conv, n_div_conv;
    logic            r_out_valid, n_out_valid;
    logic [VW-1:0]   r_out_value, n_out_value;
    logic [1:0]      r_out_status, n_out_status;

    // stack RAM ports
    logic            w_num_we;
    logic [AW-1:0]   w_num_waddr, w_num_raddr;
    logic [VW-1:0]   w_num_wdata, w_num_rdata;
    logic            w_op_we;
    logic [AW-1:0]   w_op_waddr;
    logic [2:0]      w_op_wdata, w_op_rdata;
    logic            w_br_we;
    logic [1:0]      w_br_rdata;

    // arithmetic units
    logic            w_mul_start, w_mul_done;
    logic [2*VW-1:0] w_prod;
    logic            w_div_start, w_div_done;
    logic [DW-1:0]   w_div_num, w_div_quot;
    logic [DVW-1:0]  w_div_den;

    logic [CW-1:0]   w_num_m1, w_num_m2, w_op_m1, w_br_m1;
    logic [VW-1:0]   w_ua, w_ub;
    logic [VW:0]     w_sum, w_dif;
    logic [VW+3:0]   w_acc_next;
    logic [ifx_pkg::POW10_WIDTH-1:0] w_p;
    logic [DW-1:0]   w_conv_num;
    logic            w_red_go;
    logic            w_out_take;

    assign w_num_m1 = r_num_cnt - CW'(1);
    assign w_num_m2 = r_num_cnt - CW'(2);
    assign w_op_m1  = r_op_cnt - CW'(1);
    assign w_br_m1  = r_br_cnt - CW'(1);

    assign w_ua = r_x[VW-1] ? (~r_x + VW'(1)) : r_x;
    assign w_ub = r_y[VW-1] ? (~r_y + VW'(1)) : r_y;

    assign w_sum = {r_x[VW-1], r_x} + {r_y[VW-1], r_y};
    assign w_dif = {r_x[VW-1], r_x} - {r_y[VW-1], r_y};

    // acc*10 + digit, no overflow in VW+4 bits since acc <= VMAX
    assign w_acc_next = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                      + (VW+4)'(r_char[3:0]);

    // conversion: round(acc * 2^FB / 10^frac), half up
    assign w_p        = ifx_pkg::pow10(r_frac);
    assign w_conv_num = (DW'(r_acc) << FB) + DW'(w_p >> 1);

    // reduce while the top is arithmetic (of equal or higher rank for a new operator)
    assign w_red_go = !w_op_rdata[2] &&
                      ((r_kind != K_OP) || (w_op_rdata[1] >= r_newop[1]));

    assign w_out_take = r_out_valid && o_out.ready;

    assign w_num_raddr = (r_state == S_RED_OP) ? w_num_m1[AW-1:0] :
                         (r_state == S_RD_Y)   ? w_num_m2[AW-1:0] : '0;

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_newop      = r_newop;
        n_op         = r_op;
        n_br         = r_br;
        n_num_cnt    = r_num_cnt;
        n_op_cnt     = r_op_cnt;
        n_br_cnt     = r_br_cnt;
        n_acc        = r_acc;
        n_frac       = r_frac;
        n_phase      = r_phase;
        n_err        = r_err;
        n_x          = r_x;
        n_y          = r_y;
        n_neg        = r_neg;
        n_div_conv   = r_div_conv;
        n_out_valid  = w_out_take ? 1'b0 : r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        w_num_we    = 1'b0;
        w_num_waddr = r_num_cnt[AW-1:0];
        w_num_wdata = r_acc;
        w_op_we     = 1'b0;
        w_op_waddr  = r_op_cnt[AW-1:0];
        w_op_wdata  = r_newop;
        w_br_we     = 1'b0;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_div_num   = w_conv_num;
        w_div_den   = DVW'(w_p);

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_state = S_END_CHK;
                if (r_err == ifx_pkg::ST_OK) begin
                    if (r_char inside {[ifx_pkg::CH_0:ifx_pkg::CH_9]}) begin
                        if (!(r_phase == PH_FRAC &&
                              r_frac >= 4'(MAX_FRACTION_DIGITS))) begin
                            if (r_phase == PH_NONE) begin
                                n_phase = PH_INT;
                            end
                            n_acc = (w_acc_next > (VW+4)'(VMAX)) ? VMAX
                                                                : w_acc_next[VW-1:0];
                            if (r_phase == PH_FRAC) begin
                                n_frac = r_frac + 4'd1;
                            end
                        end
                    end else begin
                        case (r_char)
                            ifx_pkg::CH_POINT: n_phase = PH_FRAC;
                            ifx_pkg::CH_PLUS: begin
                                n_kind = K_OP; n_newop = ifx_pkg::OP_ADD; n_state = S_FINISH;
                            end
                            ifx_pkg::CH_MINUS: begin
                                n_kind = K_OP; n_newop = ifx_pkg::OP_SUB; n_state = S_FINISH;
                            end
                            ifx_pkg::CH_STAR: begin
                                n_kind = K_OP; n_newop = ifx_pkg::OP_MUL; n_state = S_FINISH;
                            end
                            ifx_pkg::CH_SLASH: begin
                                n_kind = K_OP; n_newop = ifx_pkg::OP_DIV; n_state = S_FINISH;
                            end
                            ifx_pkg::CH_LROUND: begin
                                n_kind = K_OPEN; n_br = ifx_pkg::BR_ROUND; n_state = S_FINISH;
                            end
                            ifx_pkg::CH_LCURLY: begin
                                n_kind = K_OPEN; n_br = ifx_pkg::BR_CURLY; n_state = S_FINISH;
                            end
                            ifx_pkg::CH_LSQR: begin
                                n_kind = K_OPEN; n_br = ifx_pkg::BR_SQUARE; n_state = S_FINISH;
                            end
                            ifx_pkg::CH_RROUND: begin
                                n_kind = K_CLOSE; n_br = ifx_pkg::BR_ROUND; n_state = S_FINISH;
                            end
                            ifx_pkg::CH_RCURLY: begin
                                n_kind = K_CLOSE; n_br = ifx_pkg::BR_CURLY; n_state = S_FINISH;
                            end
                            ifx_pkg::CH_RSQR: begin
                                n_kind = K_CLOSE; n_br = ifx_pkg::BR_SQUARE; n_state = S_FINISH;
                            end
                            default: ;
                        endcase
                    end
                end
            end

            // close a number in progress through the divider
            S_FINISH: begin
                if (r_phase == PH_NONE) begin
                    n_state = S_AFTER;
                end else begin
                    w_div_start = 1'b1;
                    n_div_conv  = 1'b1;
                    n_state     = S_DIV;
                end
            end

            S_AFTER: begin
                case (r_kind)
                    K_OP: begin
                        n_state = (r_err == ifx_pkg::ST_OK) ? S_RED_CHK : S_END_CHK;
                    end
                    K_OPEN: begin
                        n_state = S_END_CHK;
                        if (r_err == ifx_pkg::ST_OK) begin
                            if (r_br_cnt >= CW'(STACK_DEPTH) ||
                                r_op_cnt >= CW'(STACK_DEPTH)) begin
                                n_err = ifx_pkg::ST_MALFORMED;
                            end else begin
                                w_br_we    = 1'b1;
                                w_op_we    = 1'b1;
                                w_op_wdata = {1'b1, r_br};
                                n_br_cnt   = r_br_cnt + CW'(1);
                                n_op_cnt   = r_op_cnt + CW'(1);
                            end
                        end
                    end
                    K_CLOSE: begin
                        n_state = S_END_CHK;
                        if (r_err == ifx_pkg::ST_OK) begin
                            if (r_br_cnt == '0) begin
                                n_err = ifx_pkg::ST_BRACKET;
                            end else begin
                                n_state = S_BR_RD;
                            end
                        end
                    end
                    default: begin
                        // end of expression
                        n_state = S_OUT;
                        if (r_err == ifx_pkg::ST_OK) begin
                            if (r_br_cnt != '0) begin
                                n_err = ifx_pkg::ST_BRACKET;
                            end else begin
                                n_state = S_RED_CHK;
                            end
                        end
                    end
                endcase
            end

            S_BR_RD: begin
                if (w_br_rdata != r_br) begin
                    n_err   = ifx_pkg::ST_BRACKET;
                    n_state = S_END_CHK;
                end else begin
                    n_br_cnt = w_br_m1;
                    n_state  = S_RED_CHK;
                end
            end

            S_RED_CHK: begin
                if (r_err != ifx_pkg::ST_OK || r_op_cnt == '0) begin
                    n_state = S_RED_EXIT;
                end else begin
                    n_state = S_RED_OP;
                end
            end

            S_RED_OP: begin
                if (!w_red_go) begin
                    n_state = S_RED_EXIT;
                end else begin
                    n_op     = ifx_pkg::t_op'(w_op_rdata);
                    n_op_cnt = w_op_m1;
                    if (r_num_cnt < CW'(2)) begin
                        n_err   = ifx_pkg::ST_MALFORMED;
                        n_state = S_RED_EXIT;
                    end else begin
                        n_state = S_RD_Y;
                    end
                end
            end

            S_RD_Y: begin
                n_y     = w_num_rdata;
                n_state = S_RD_X;
            end

            S_RD_X: begin
                n_x     = w_num_rdata;
                n_state = S_ALU;
            end

            S_ALU: begin
                n_neg       = r_x[VW-1] ^ r_y[VW-1];
                w_num_waddr = w_num_m2[AW-1:0];
                case (r_op)
                    ifx_pkg::OP_ADD: begin
                        w_num_we    = 1'b1;
                        w_num_wdata = (w_sum[VW] != w_sum[VW-1]) ?
                                      (w_sum[VW] ? VMIN : VMAX) : w_sum[VW-1:0];
                        n_num_cnt   = w_num_m1;
                        n_state     = S_RED_CHK;
                    end
                    ifx_pkg::OP_SUB: begin
                        w_num_we    = 1'b1;
                        w_num_wdata = (w_dif[VW] != w_dif[VW-1]) ?
                                      (w_dif[VW] ? VMIN : VMAX) : w_dif[VW-1:0];
                        n_num_cnt   = w_num_m1;
                        n_state     = S_RED_CHK;
                    end
                    ifx_pkg::OP_MUL: begin
                        w_mul_start = 1'b1;
                        n_state     = S_MUL;
                    end
                    default: begin
                        if (r_y == '0) begin
                            n_err   = ifx_pkg::ST_DIV_ZERO;
                            n_state = S_RED_EXIT;
                        end else begin
                            w_div_start = 1'b1;
                            w_div_num   = DW'(w_ua) << FB;
                            w_div_den   = DVW'(w_ub);
                            n_div_conv  = 1'b0;
                            n_state     = S_DIV;
                        end
                    end
                endcase
            end

            S_MUL: begin
                w_num_waddr = w_num_m2[AW-1:0];
                if (w_mul_done) begin
                    w_num_we    = 1'b1;
                    w_num_wdata = sat_signed(MW'(w_prod >> FB), r_neg);
                    n_num_cnt   = w_num_m1;
                    n_state     = S_RED_CHK;
                end
            end

            S_DIV: begin
                if (w_div_done) begin
                    if (r_div_conv) begin
                        // converted number: clamp and push
                        n_phase = PH_NONE;
                        n_acc   = '0;
                        n_frac  = '0;
                        n_state = S_AFTER;
                        w_num_wdata = (w_div_quot > DW'(VMAX)) ? VMAX : w_div_quot[VW-1:0];
                        if (r_num_cnt >= CW'(STACK_DEPTH)) begin
                            n_err = ifx_pkg::ST_MALFORMED;
                        end else begin
                            w_num_we  = 1'b1;
                            n_num_cnt = r_num_cnt + CW'(1);
                        end
                    end else begin
                        w_num_we    = 1'b1;
                        w_num_waddr = w_num_m2[AW-1:0];
                        w_num_wdata = sat_signed(MW'(w_div_quot), r_neg);
                        n_num_cnt   = w_num_m1;
                        n_state     = S_RED_CHK;
                    end
                end
            end

            S_RED_EXIT: begin
                case (r_kind)
                    K_OP: begin
                        n_state = S_END_CHK;
                        if (r_err == ifx_pkg::ST_OK) begin
                            if (r_op_cnt >= CW'(STACK_DEPTH)) begin
                                n_err = ifx_pkg::ST_MALFORMED;
                            end else begin
                                w_op_we  = 1'b1;
                                n_op_cnt = r_op_cnt + CW'(1);
                            end
                        end
                    end
                    K_CLOSE: begin
                        n_state = S_END_CHK;
                        // drop the matching open bracket
                        if (r_err == ifx_pkg::ST_OK && r_op_cnt != '0) begin
                            n_op_cnt = w_op_m1;
                        end
                    end
                    default: begin
                        n_state = S_RES_RD;
                        if (r_err == ifx_pkg::ST_OK &&
                            (r_op_cnt != '0 || r_num_cnt != CW'(1))) begin
                            n_err = ifx_pkg::ST_MALFORMED;
                        end
                    end
                endcase
            end

            S_END_CHK: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_err != ifx_pkg::ST_OK) begin
                    n_state = S_OUT;
                end else begin
                    n_kind  = K_END;
                    n_state = S_FINISH;
                end
            end

            S_RES_RD: begin
                n_state = S_OUT;
            end

            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = (r_err == ifx_pkg::ST_OK) ? w_num_rdata : '0;
                    n_out_status = r_err;
                    n_num_cnt    = '0;
                    n_op_cnt     = '0;
                    n_br_cnt     = '0;
                    n_acc        = '0;
                    n_frac       = '0;
                    n_phase      = PH_NONE;
                    n_err        = ifx_pkg::ST_OK;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= K_OP;
            r_num_cnt   <= '0;
            r_op_cnt    <= '0;
            r_br_cnt    <= '0;
            r_acc       <= '0;
            r_frac      <= '0;
            r_phase     <= PH_NONE;
            r_err       <= ifx_pkg::ST_OK;
            r_div_conv  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_num_cnt   <= n_num_cnt;
            r_op_cnt    <= n_op_cnt;
            r_br_cnt    <= n_br_cnt;
            r_acc       <= n_acc;
            r_frac      <= n_frac;
            r_phase     <= n_phase;
            r_err       <= n_err;
            r_div_conv  <= n_div_conv;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_char <= i_in.character;
            r_last <= i_in.last;
        end
        r_newop      <= n_newop;
        r_op         <= n_op;
        r_br         <= n_br;
        r_x          <= n_x;
        r_y          <= n_y;
        r_neg        <= n_neg;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_out_value;
    assign o_out.status = r_out_status;

    ifx_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_num_ram (
        .i_clk   (i_clk),
        .i_we    (w_num_we),
        .i_waddr (w_num_waddr),
        .i_wdata (w_num_wdata),
        .i_raddr (w_num_raddr),
        .o_rdata (w_num_rdata)
    );

    ifx_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_op_ram (
        .i_clk   (i_clk),
        .i_we    (w_op_we),
        .i_waddr (w_op_waddr),
        .i_wdata (w_op_wdata),
        .i_raddr (w_op_m1[AW-1:0]),
        .o_rdata (w_op_rdata)
    );

    ifx_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_br_ram (
        .i_clk   (i_clk),
        .i_we    (w_br_we),
        .i_waddr (r_br_cnt[AW-1:0]),
        .i_wdata (r_br),
        .i_raddr (w_br_m1[AW-1:0]),
        .o_rdata (w_br_rdata)
    );

    ifx_mul #(.VALUE_WIDTH(VW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ua),
        .i_b     (w_ub),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    ifx_div #(.NUM_WIDTH(DW), .DEN_WIDTH(DVW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

endmodule

`default_nettype wire
